### rtl/core/ttm_pkg.sv
// Package for the two-tape Turing machine engine.
// Holds the channel payload types, the transition entry, codes and the sequencer states.
// No dependencies.
package ttm_pkg;

   localparam logic [7:0] BLANK_SYM = 8'h23;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_WRITE = 2'd1,
      OP_RUN   = 2'd2,
      OP_READ  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      MV_STAY  = 2'd0,
      MV_LEFT  = 2'd1,
      MV_RIGHT = 2'd2
   } move_type;

   typedef enum logic [2:0] {
      STS_DONE     = 3'd0,
      STS_ACCEPTED = 3'd1,
      STS_BLOCKED  = 3'd2,
      STS_LIMIT    = 3'd3,
      STS_OFF_TAPE = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CSR_START_STATE = 2'd0,
      CSR_FINAL_MASK  = 2'd1,
      CSR_IN_USE      = 2'd2,
      CSR_MAX_STEPS   = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_TAPE,
      ST_SCAN,
      ST_FIRE,
      ST_DONE
   } seq_state_type;

   typedef struct packed {
      logic [3:0] from_state;
      logic [7:0] read_sym_one;
      logic [7:0] read_sym_two;
      logic [3:0] to_state;
      logic [7:0] write_sym_one;
      logic [1:0] move_one;
      logic [7:0] write_sym_two;
      logic [1:0] move_two;
   } entry_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [11:0] index;
      logic        tape_select;
      logic [3:0]  from_state;
      logic [7:0]  read_sym_one;
      logic [7:0]  read_sym_two;
      logic [3:0]  to_state;
      logic [7:0]  write_sym_one;
      logic [1:0]  move_one;
      logic [7:0]  write_sym_two;
      logic [1:0]  move_two;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  read_symbol;
      logic [3:0]  final_state;
      logic [31:0] steps_taken;
      logic [11:0] head_one_pos;
      logic [11:0] head_two_pos;
   } rsp_type;

endpackage

### rtl/core/ttm_chan_if.sv
// Valid/ready channel interfaces for requests and responses of the engine.
// Depends on ttm_pkg for the payload types.
interface ttm_req_if import ttm_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ttm_rsp_if import ttm_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### rtl/core/ttm_table.sv
// Transition table memory: one write port, one registered read port.
// Depends on ttm_pkg for the entry type.
module ttm_table import ttm_pkg::*; #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output entry_type     rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/ttm_tape.sv
// One tape memory with a registered read port and a blanking pass after reset.
// Depends on ttm_pkg for the blank symbol.
module ttm_tape import ttm_pkg::*; #(
   parameter int CELLS = 4096,
   parameter int AW    = 12
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data,
   output logic          busy
);

   logic [7:0]    mem [CELLS];
   logic [7:0]    rd_data_ff;
   logic          clr_ff;
   logic          clr_in;
   logic [AW-1:0] clr_cnt_ff;
   logic [AW-1:0] clr_cnt_in;

   always_comb begin
      clr_in     = clr_ff;
      clr_cnt_in = clr_cnt_ff;
      if (clr_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == AW'(CELLS - 1)) begin
            clr_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
      end else begin
         clr_ff     <= clr_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_ff) begin
         mem[clr_cnt_ff] <= BLANK_SYM;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_ff;

endmodule

### rtl/core/two_tape_turing_machine_engine_unit.sv
// Top level of the two-tape Turing machine engine: sequencer, heads and registers.
// Depends on ttm_pkg, ttm_chan_if, ttm_table and ttm_tape.
//
// Channel  Direction  Transaction
// req      in         one opcode item (load entry, write cell, run, read cell)
// rsp      out        one result per request
// csr      in         register write, index and data, no handshake
//
// Load, write and read items pass from idle straight to the done state. A run takes per
// step a tape read, a scan of up to transitions_in_use table entries through the
// single table read port, and a fire of the matching entry, then a done state to finish.
// After reset both tapes are blanked one cell a cycle, all TAPE_CELLS cells, before req
// becomes ready; register writes are taken throughout. A response waiting on rsp holds
// the engine in its final state, but the next request may already have been taken.
module two_tape_turing_machine_engine_unit import ttm_pkg::*; #(
   parameter int MAX_TRANSITIONS = 64,
   parameter int TAPE_CELLS      = 4096,
   parameter int NUM_STATES      = 16
) (
   input  logic        clock,
   input  logic        reset,
   ttm_req_if.sink     req,
   ttm_rsp_if.source   rsp,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int TAW = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
   localparam int LW  = $clog2(MAX_TRANSITIONS + 1);
   localparam int TW  = $clog2(TAPE_CELLS);

   seq_state_type state_ff, state_in;

   logic [3:0]  start_state_ff;
   logic [15:0] final_mask_ff;
   logic [6:0]  in_use_ff;
   logic [31:0] max_steps_ff;

   req_type     cur_req_ff, cur_req_in;
   logic [2:0]  stat_ff, stat_in;
   logic [3:0]  cur_state_ff, cur_state_in;
   logic [TW-1:0] head1_ff, head1_in, head2_ff, head2_in;
   logic [31:0] step_ff, step_in;
   logic [LW-1:0] scan_ff, scan_in;
   logic        cmp_vld_ff, cmp_vld_in;

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic [LW-1:0] limit;
   logic        accept;
   logic        idx_tape_ok;
   logic [TW-1:0] idx_cell;
   logic        hit;
   logic        busy1, busy2;

   logic        tb_we, tb_re;
   logic [TAW-1:0] tb_raddr;
   entry_type   tb_wdata, tb_rdata;

   logic        t1_we, t2_we, t_re;
   logic [TW-1:0] t1_waddr, t2_waddr, t1_raddr, t2_raddr;
   logic [7:0]  t1_wdata, t2_wdata, t1_rdata, t2_rdata;

   logic        off1, off2;
   logic [TW-1:0] new_head1, new_head2;
   logic        accepting;
   logic [7:0]  rsym;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_state_ff <= '0;
         final_mask_ff  <= '0;
         in_use_ff      <= '0;
         max_steps_ff   <= '1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_START_STATE: start_state_ff <= csr_data[3:0];
            CSR_FINAL_MASK:  final_mask_ff  <= csr_data[15:0];
            CSR_IN_USE:      in_use_ff      <= csr_data[6:0];
            CSR_MAX_STEPS:   max_steps_ff   <= csr_data;
            default:         ;
         endcase
      end
   end

   assign limit = (32'(in_use_ff) > MAX_TRANSITIONS) ? LW'(MAX_TRANSITIONS) : LW'(in_use_ff);

   assign req.ready   = (state_ff == ST_IDLE);
   assign accept      = req.valid && req.ready;
   assign idx_tape_ok = 32'(req.data.index) < TAPE_CELLS;
   assign idx_cell    = TW'(req.data.index);

   assign hit = cmp_vld_ff && (tb_rdata.from_state == cur_state_ff) &&
                (tb_rdata.read_sym_one == t1_rdata) && (tb_rdata.read_sym_two == t2_rdata);

   // Head moves for the entry held on the table read port.
   always_comb begin
      off1      = 1'b0;
      off2      = 1'b0;
      new_head1 = head1_ff;
      new_head2 = head2_ff;
      case (tb_rdata.move_one)
         MV_LEFT: begin
            if (head1_ff == '0) off1 = 1'b1;
            else new_head1 = head1_ff - 1'b1;
         end
         MV_RIGHT: begin
            if (head1_ff == TW'(TAPE_CELLS - 1)) off1 = 1'b1;
            else new_head1 = head1_ff + 1'b1;
         end
         default: ;
      endcase
      case (tb_rdata.move_two)
         MV_LEFT: begin
            if (head2_ff == '0) off2 = 1'b1;
            else new_head2 = head2_ff - 1'b1;
         end
         MV_RIGHT: begin
            if (head2_ff == TW'(TAPE_CELLS - 1)) off2 = 1'b1;
            else new_head2 = head2_ff + 1'b1;
         end
         default: ;
      endcase
   end

   assign accepting = (32'(cur_state_ff) < NUM_STATES) && final_mask_ff[cur_state_ff];

   always_comb begin
      rsym = '0;
      if ((cur_req_ff.opcode == OP_READ) && (32'(cur_req_ff.index) < TAPE_CELLS)) begin
         rsym = cur_req_ff.tape_select ? t2_rdata : t1_rdata;
      end
   end

   // Sequencer: next state and memory controls.
   always_comb begin
      state_in     = state_ff;
      cur_req_in   = cur_req_ff;
      stat_in      = stat_ff;
      cur_state_in = cur_state_ff;
      head1_in     = head1_ff;
      head2_in     = head2_ff;
      step_in      = step_ff;
      scan_in      = scan_ff;
      cmp_vld_in   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_data_in  = rsp_data_ff;

      tb_we    = 1'b0;
      tb_wdata = entry_type'{req.data.from_state, req.data.read_sym_one,
                             req.data.read_sym_two, req.data.to_state,
                             req.data.write_sym_one, req.data.move_one,
                             req.data.write_sym_two, req.data.move_two};
      tb_re    = 1'b0;
      tb_raddr = scan_ff[TAW-1:0];
      t1_we    = 1'b0;
      t2_we    = 1'b0;
      t1_waddr = idx_cell;
      t2_waddr = idx_cell;
      t1_wdata = req.data.write_sym_one;
      t2_wdata = req.data.write_sym_one;
      t_re     = 1'b0;
      t1_raddr = idx_cell;
      t2_raddr = idx_cell;

      case (state_ff)
         ST_CLEAR: begin
            if (!busy1 && !busy2) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               cur_req_in = req.data;
               stat_in    = STS_DONE;
               state_in   = ST_DONE;
               case (req.data.opcode)
                  OP_LOAD: begin
                     tb_we = 32'(req.data.index) < MAX_TRANSITIONS;
                  end
                  OP_WRITE: begin
                     t1_we = idx_tape_ok && !req.data.tape_select;
                     t2_we = idx_tape_ok && req.data.tape_select;
                  end
                  OP_RUN: begin
                     cur_state_in = start_state_ff;
                     head1_in     = TW'(1);
                     head2_in     = TW'(1);
                     step_in      = '0;
                     state_in     = ST_TAPE;
                  end
                  default: begin
                     t_re = 1'b1;
                  end
               endcase
            end
         end
         ST_TAPE: begin
            t_re     = 1'b1;
            t1_raddr = head1_ff;
            t2_raddr = head2_ff;
            scan_in  = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (hit) begin
               if (step_ff == max_steps_ff) begin
                  stat_in  = STS_LIMIT;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_FIRE;
               end
            end else if (scan_ff < limit) begin
               tb_re      = 1'b1;
               scan_in    = scan_ff + 1'b1;
               cmp_vld_in = 1'b1;
            end else if (!cmp_vld_ff) begin
               stat_in  = accepting ? STS_ACCEPTED : STS_BLOCKED;
               state_in = ST_DONE;
            end
         end
         ST_FIRE: begin
            t1_we        = 1'b1;
            t2_we        = 1'b1;
            t1_waddr     = head1_ff;
            t2_waddr     = head2_ff;
            t1_wdata     = tb_rdata.write_sym_one;
            t2_wdata     = tb_rdata.write_sym_two;
            head1_in     = new_head1;
            head2_in     = new_head2;
            cur_state_in = tb_rdata.to_state;
            step_in      = step_ff + 1'b1;
            if (off1 || off2) begin
               stat_in  = STS_OFF_TAPE;
               state_in = ST_DONE;
            end else begin
               state_in = ST_TAPE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rsp_type'{stat_ff, rsym, cur_state_ff, step_ff,
                                        12'(head1_ff), 12'(head2_ff)};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         cur_state_ff <= '0;
         head1_ff     <= TW'(1);
         head2_ff     <= TW'(1);
         step_ff      <= '0;
         cmp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_state_ff <= cur_state_in;
         head1_ff     <= head1_in;
         head2_ff     <= head2_in;
         step_ff      <= step_in;
         cmp_vld_ff   <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_req_ff  <= cur_req_in;
      stat_ff     <= stat_in;
      scan_ff     <= scan_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;

   ttm_table #(.DEPTH(MAX_TRANSITIONS), .AW(TAW)) u_table (
      .clock   (clock),
      .wr_en   (tb_we),
      .wr_addr (TAW'(req.data.index)),
      .wr_data (tb_wdata),
      .rd_en   (tb_re),
      .rd_addr (tb_raddr),
      .rd_data (tb_rdata)
   );

   ttm_tape #(.CELLS(TAPE_CELLS), .AW(TW)) u_tape_one (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (t1_we),
      .wr_addr (t1_waddr),
      .wr_data (t1_wdata),
      .rd_en   (t_re),
      .rd_addr (t1_raddr),
      .rd_data (t1_rdata),
      .busy    (busy1)
   );

   ttm_tape #(.CELLS(TAPE_CELLS), .AW(TW)) u_tape_two (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (t2_we),
      .wr_addr (t2_waddr),
      .wr_data (t2_wdata),
      .rd_en   (t_re),
      .rd_addr (t2_raddr),
      .rd_data (t2_rdata),
      .busy    (busy2)
   );

endmodule
